// ===== src/ir_mpd_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// IR multi-press detector package
// Shared types, remote code table and classification helpers for the
// multi-press detector core, its result queue and its port checker.
// ============================================================================

package ir_mpd_pkg;

    // Operation carried in the input tuser.
    typedef enum logic {
        OP_CODE = 1'b0,
        OP_POLL = 1'b1
    } op_t;

    // Action class reported with a closed run.
    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_SINGLE    = 3'd1,
        ACT_DOUBLE    = 3'd2,
        ACT_TRIPLE    = 3'd3,
        ACT_FIVE_PLUS = 3'd4
    } action_t;

    // Configuration register indexes.
    localparam logic [1:0] REG_WINDOW_MAX = 2'd0;
    localparam logic [1:0] REG_WINDOW_MIN = 2'd1;

    // Register reset values.
    localparam logic [15:0] WINDOW_MAX_RESET = 16'd2000;
    localparam logic [15:0] WINDOW_MIN_RESET = 16'd200;

    // Button codes inside a group.
    localparam logic [2:0] POWER_BUTTON = 3'd4;
    localparam logic [2:0] NO_BUTTON    = 3'd7;
    localparam int unsigned GROUP_BUTTONS = 5;

    // Depth of the result queue.
    localparam int unsigned QUEUE_DEPTH = 4;

    // Known remote codes, one row per group, buttons 0..3 then power.
    localparam logic [31:0] GROUP_CODES [2][GROUP_BUTTONS] = '{
        '{32'd2733166887, 32'd1663147656, 32'd1494494661, 32'd3967086620,
          32'd3909119151},
        '{32'd4257650505, 32'd271251858,  32'd2952684369, 32'd2508896912,
          32'd1937930936}
    };

    // Outcome of a code table lookup.
    typedef struct packed {
        logic       hit;
        logic       grp;
        logic [2:0] btn;
    } code_hit_t;

    // One result word as held in the queue.
    typedef struct packed {
        logic       group_id;
        logic [2:0] button;
        logic [7:0] press_count;
        action_t    action;
        logic       last;
    } result_t;

    // Looks a raw code up in the table; codes are all distinct.
    function automatic code_hit_t match_code(logic [31:0] code);
        code_hit_t res;
        res = '{hit: 1'b0, grp: 1'b0, btn: 3'd0};
        for (int g = 0; g < 2; g++) begin
            for (int b = 0; b < GROUP_BUTTONS; b++) begin
                if (code == GROUP_CODES[g][b]) begin
                    res.hit = 1'b1;
                    res.grp = 1'(g);
                    res.btn = 3'(b);
                end
            end
        end
        return res;
    endfunction

    // Maps a closed run to its action class.
    function automatic action_t classify(logic grp, logic [2:0] btn, logic [7:0] cnt);
        action_t act;
        if (cnt == 8'd1) begin
            act = ACT_SINGLE;
        end else if (cnt == 8'd2) begin
            act = ACT_DOUBLE;
        end else if (btn == POWER_BUTTON) begin
            act = (!grp && cnt == 8'd3) ? ACT_TRIPLE : ACT_NONE;
        end else if (cnt >= 8'd5) begin
            act = ACT_FIVE_PLUS;
        end else begin
            act = ACT_NONE;
        end
        return act;
    endfunction

endpackage

// ===== src/ir_mpd_fifo.sv =====
`timescale 1ns / 1ps
// ============================================================================
// IR multi-press detector result queue
// Small register queue that takes zero, one or two result words per cycle
// and hands out one word per cycle, while rd_ready is high, on a valid/ready output.
// ============================================================================

module ir_mpd_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [1:0]          wr_num,
    input  ir_mpd_pkg::result_t wr_data0,
    input  ir_mpd_pkg::result_t wr_data1,
    output logic                room_for_two,
    output logic                rd_valid,
    input  logic                rd_ready,
    output ir_mpd_pkg::result_t rd_data
);

    localparam int unsigned PTR_BITS = $clog2(ir_mpd_pkg::QUEUE_DEPTH);
    localparam int unsigned CNT_BITS = $clog2(ir_mpd_pkg::QUEUE_DEPTH + 1);

    ir_mpd_pkg::result_t mem_reg [ir_mpd_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                pop;

    assign rd_valid     = (count_reg != '0);
    assign rd_data      = mem_reg[rd_ptr_reg];
    assign pop          = rd_valid && rd_ready;
    assign room_for_two = (count_reg <= CNT_BITS'(ir_mpd_pkg::QUEUE_DEPTH - 2));

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_BITS'(wr_num);
        rd_ptr_next = rd_ptr_reg + PTR_BITS'(pop);
        count_next  = count_reg + CNT_BITS'(wr_num) - CNT_BITS'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Word storage; the second word goes to the slot after the first.
    always_ff @(posedge aclk) begin
        if (wr_num != 2'd0) begin
            mem_reg[wr_ptr_reg] <= wr_data0;
        end
        if (wr_num == 2'd2) begin
            mem_reg[wr_ptr_reg + PTR_BITS'(1)] <= wr_data1;
        end
    end

endmodule

// ===== src/ir_multi_press_detector_core.sv =====
`timescale 1ns / 1ps
// Path: an accepted word waits in the input register until the queue has room for
// two results, then updates the groups and the queue, whose words drive m_tvalid.
// Throughput: one input word per cycle while the queue has room for two results; a
// poll that closes both groups puts two result words into the four-entry output queue,
// which drains one word per cycle while m_tready is high. Reset: synchronous, active low;
// clears the groups and the queue and sets the windows to 2000 ms max, 200 ms min.
// ============================================================================
// IR multi-press detector core
// Counts repeated presses of remote buttons in two groups and reports each
// run with its press count and action class when a poll finds it timed out.
// ============================================================================

module ir_multi_press_detector_core #(
    parameter int unsigned TIME_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] code, [63:32] now_ms
    input  logic        s_tuser,   // [0] operation
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [2:0] button, [10:3] press_count, [13:11] action
    output logic        m_tuser,   // [0] group_id
    output logic        m_tlast,   // last_of_run
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // Input stage
    logic                 in_vld_reg;
    ir_mpd_pkg::op_t      in_op_reg;
    logic [31:0]          in_code_reg;
    logic [TIME_BITS-1:0] in_now_reg;
    logic                 advance;
    logic                 room_for_two;

    // Configuration
    logic [15:0]          win_max_reg;
    logic [15:0]          win_min_reg;
    logic [TIME_BITS-1:0] win_max_ext;
    logic [TIME_BITS-1:0] win_min_ext;

    // Group state
    logic [2:0]           btn_reg  [2];
    logic [7:0]           cnt_reg  [2];
    logic [TIME_BITS-1:0] time_reg [2];
    logic [2:0]           btn_next  [2];
    logic [7:0]           cnt_next  [2];
    logic [TIME_BITS-1:0] time_next [2];
    logic                 expire [2];
    ir_mpd_pkg::result_t  res [2];

    ir_mpd_pkg::code_hit_t hit;

    // Queue write side
    logic [1:0]           wr_num;
    ir_mpd_pkg::result_t  wr_data0;
    ir_mpd_pkg::result_t  wr_data1;
    ir_mpd_pkg::result_t  rd_data;

    assign cfg_ready = 1'b1;
    assign advance   = in_vld_reg && room_for_two;
    assign s_tready  = !in_vld_reg || room_for_two;

    // Input register: holds one word until the queue has room for two results.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_vld_reg <= 1'b1;
        end else if (advance) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg   <= ir_mpd_pkg::op_t'(s_tuser);
            in_code_reg <= s_tdata[31:0];
            in_now_reg  <= s_tdata[32 +: TIME_BITS];
        end
    end

    // Window registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_max_reg <= ir_mpd_pkg::WINDOW_MAX_RESET;
            win_min_reg <= ir_mpd_pkg::WINDOW_MIN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                ir_mpd_pkg::REG_WINDOW_MAX: win_max_reg <= cfg_data;
                ir_mpd_pkg::REG_WINDOW_MIN: win_min_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign win_max_ext = TIME_BITS'(win_max_reg);
    assign win_min_ext = TIME_BITS'(win_min_reg);

    assign hit = ir_mpd_pkg::match_code(in_code_reg);

    // Per-group press and poll logic.
    for (genvar gi = 0; gi < 2; gi++) begin : g_group
        logic                 sel_press;
        logic                 new_btn;
        logic [7:0]           cnt_eff;
        logic [TIME_BITS-1:0] time_eff;
        logic [TIME_BITS-1:0] press_gap;
        logic [TIME_BITS-1:0] poll_gap;
        logic                 in_win;

        always_comb begin
            sel_press = advance && (in_op_reg == ir_mpd_pkg::OP_CODE) && hit.hit
                        && (hit.grp == 1'(gi));
            new_btn   = (btn_reg[gi] != hit.btn);
            // A new button restarts the run from time zero.
            cnt_eff   = new_btn ? 8'd0 : cnt_reg[gi];
            time_eff  = new_btn ? '0 : time_reg[gi];
            press_gap = in_now_reg - time_eff;
            in_win    = (press_gap < win_max_ext) && (press_gap > win_min_ext);
            poll_gap  = in_now_reg - time_reg[gi];
            expire[gi] = advance && (in_op_reg == ir_mpd_pkg::OP_POLL)
                         && (cnt_reg[gi] != 8'd0) && (poll_gap > win_max_ext);
        end

        // Next state of the group.
        always_comb begin
            btn_next[gi]  = btn_reg[gi];
            cnt_next[gi]  = cnt_reg[gi];
            time_next[gi] = time_reg[gi];
            if (sel_press) begin
                btn_next[gi]  = hit.btn;
                time_next[gi] = in_now_reg;
                if (in_win) begin
                    cnt_next[gi] = (cnt_eff == 8'hFF) ? cnt_eff : cnt_eff + 8'd1;
                end else begin
                    cnt_next[gi] = (cnt_eff == 8'd0) ? 8'd1 : cnt_eff;
                end
            end else if (expire[gi]) begin
                btn_next[gi]  = ir_mpd_pkg::NO_BUTTON;
                cnt_next[gi]  = 8'd0;
                time_next[gi] = '0;
            end
        end

        // Result word for a run closed by this poll.
        always_comb begin
            res[gi].group_id    = 1'(gi);
            res[gi].button      = btn_reg[gi];
            res[gi].press_count = cnt_reg[gi];
            res[gi].action      = ir_mpd_pkg::classify(1'(gi), btn_reg[gi], cnt_reg[gi]);
            res[gi].last        = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int g = 0; g < 2; g++) begin
                btn_reg[g]  <= ir_mpd_pkg::NO_BUTTON;
                cnt_reg[g]  <= 8'd0;
                time_reg[g] <= '0;
            end
        end else begin
            for (int g = 0; g < 2; g++) begin
                btn_reg[g]  <= btn_next[g];
                cnt_reg[g]  <= cnt_next[g];
                time_reg[g] <= time_next[g];
            end
        end
    end

    // Pack closed runs in group order; the final word carries last.
    always_comb begin
        wr_num   = 2'(expire[0]) + 2'(expire[1]);
        wr_data0 = expire[0] ? res[0] : res[1];
        wr_data0.last = !(expire[0] && expire[1]);
        wr_data1 = res[1];
        wr_data1.last = 1'b1;
    end

    ir_mpd_fifo u_fifo (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .wr_num       (wr_num),
        .wr_data0     (wr_data0),
        .wr_data1     (wr_data1),
        .room_for_two (room_for_two),
        .rd_valid     (m_tvalid),
        .rd_ready     (m_tready),
        .rd_data      (rd_data)
    );

    assign m_tdata = {2'b00, rd_data.action, rd_data.press_count, rd_data.button};
    assign m_tuser = rd_data.group_id;
    assign m_tlast = rd_data.last;

endmodule

// ===== src/ir_mpd_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// IR multi-press detector port checker
// Watches the result stream of the core and flags words that no closed run
// could produce, or a word that changes while it is stalled.
// ============================================================================

module ir_mpd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // A stalled word stays put.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result word changed while stalled");

    // Only open runs are reported, so the count is never zero.
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[10:3] != 8'd0)
        else $error("closed run reported with zero presses");

    // Buttons and actions stay in their ranges; spare bits are zero.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] <= ir_mpd_pkg::POWER_BUTTON)
                     && (m_tdata[13:11] <= 3'(ir_mpd_pkg::ACT_FIVE_PLUS))
                     && (m_tdata[15:14] == 2'b00))
        else $error("result field out of range");

    // A triple press is only recognized on the first group's power button.
    a_triple: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[13:11] == 3'(ir_mpd_pkg::ACT_TRIPLE))
        |-> (m_tdata[2:0] == ir_mpd_pkg::POWER_BUTTON) && !m_tuser
            && (m_tdata[10:3] == 8'd3))
        else $error("triple action on wrong button or count");

    // The second group's word always ends a poll's results.
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("second group word not marked last");

endmodule

bind ir_multi_press_detector_core ir_mpd_checker u_ir_mpd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
